// ===== hdl/slir_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slir_pkg
// Shared types and constants for the sorted list insert/remove block.
// ----------------------------------------------------------------------------
package slir_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_REMOVE = 1'b1
    } t_func;

    typedef struct packed {
        logic ins_en;
        logic rem_en;
    } t_cell_ctl;

endpackage

// ===== hdl/sorted_list_insert_remove.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_insert_remove
// Bounded table of signed values kept in ascending order, with insert and
// remove operations.
// ----------------------------------------------------------------------------
// The input channel (i_valid, o_ready) carries one beat per operation: i_func
// selects insert or remove and i_value is the signed operand. Each beat gives
// exactly one beat on the output channel (o_valid, i_ready) with the entry
// count after the operation and the not_found and full_drop flags.
// The table is a row of DEPTH cells. Every cell compares its entry with the
// operand in parallel, so one beat is applied at once and the result appears
// in the output register in the cycle after acceptance.
// Throughput is one beat per cycle while the output is not stalled by i_ready,
// set by the parallel compare and shift across the cell row.
// A result waiting in the output register holds while i_ready is low; a new
// beat is accepted in the same cycle the waiting result is taken.
// Reset empties the table and the output register; the entries themselves
// are not cleared, since only occupied cells are ever compared.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove #(
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_func,
    input  logic signed [slir_pkg::VALUE_W-1:0]  i_value,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [slir_pkg::COUNT_W-1:0]         o_count,
    output logic                                 o_not_found,
    output logic                                 o_full_drop
);
    import slir_pkg::*;

    localparam int HeldW = $clog2(DEPTH + 1);
    localparam int ExtW  = HeldW + COUNT_W;

    logic [HeldW-1:0]          r_held;
    logic [HeldW-1:0]          n_held;
    logic                      r_o_valid;
    logic [COUNT_W-1:0]        r_count;
    logic                      r_not_found;
    logic                      r_full_drop;
    logic [ExtW-1:0]           w_held_ext;

    logic                      w_beat;
    logic                      w_full;
    logic                      w_found;
    t_cell_ctl                 w_ctl;
    logic [DEPTH-1:0]          w_lt;
    logic [DEPTH-1:0]          w_eq;
    logic [DEPTH-1:0]          w_occ;
    logic signed [VALUE_W-1:0] w_entry [DEPTH];

    assign o_ready = !r_o_valid || i_ready;
    assign w_beat  = i_valid && o_ready;
    assign w_full  = (r_held == HeldW'(DEPTH));
    assign w_found = |w_eq;

    assign w_ctl.ins_en = w_beat && (t_func'(i_func) == FUNC_INSERT) && !w_full;
    assign w_ctl.rem_en = w_beat && (t_func'(i_func) == FUNC_REMOVE) && w_found;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic signed [VALUE_W-1:0] w_left;
            logic signed [VALUE_W-1:0] w_right;
            logic                      w_left_lt;

            assign w_occ[g] = (HeldW'(g) < r_held);

            if (g == 0) begin : g_first
                assign w_left    = i_value;
                assign w_left_lt = 1'b1;
            end else begin : g_inner
                assign w_left    = w_entry[g-1];
                assign w_left_lt = w_lt[g-1];
            end

            if (g == DEPTH - 1) begin : g_last
                assign w_right = w_entry[g];
            end else begin : g_mid
                assign w_right = w_entry[g+1];
            end

            slir_cell u_cell (
                .i_clk         (i_clk),
                .i_ctl         (w_ctl),
                .i_occupied    (w_occ[g]),
                .i_value       (i_value),
                .i_left_entry  (w_left),
                .i_left_lt     (w_left_lt),
                .i_right_entry (w_right),
                .o_entry       (w_entry[g]),
                .o_lt          (w_lt[g]),
                .o_eq          (w_eq[g])
            );
        end
    endgenerate

    always_comb begin
        n_held = r_held;
        if (w_ctl.ins_en) begin
            n_held = r_held + HeldW'(1);
        end else if (w_ctl.rem_en) begin
            n_held = r_held - HeldW'(1);
        end
    end

    assign w_held_ext = ExtW'(n_held);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_held <= n_held;
            if (w_beat) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_beat) begin
            r_count     <= w_held_ext[COUNT_W-1:0];
            r_not_found <= (t_func'(i_func) == FUNC_REMOVE) && !w_found;
            r_full_drop <= (t_func'(i_func) == FUNC_INSERT) && w_full;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_count     = r_count;
    assign o_not_found = r_not_found;
    assign o_full_drop = r_full_drop;

`ifndef SYNTH
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= HeldW'(DEPTH))
        else $error("Entry count exceeds table depth.");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_not_found && o_full_drop))
        else $error("Both result flags are set.");

    a_full_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_beat && w_full && (t_func'(i_func) == FUNC_INSERT) |=> w_full)
        else $error("Dropped insert changed the count.");

    a_miss_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_beat && !w_found && (t_func'(i_func) == FUNC_REMOVE)
        |=> r_held == $past(r_held))
        else $error("Unmatched remove changed the count.");
`endif

endmodule

// ===== hdl/slir_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slir_cell
// One slot of the sorted table: compares its entry with the operand and
// shifts toward either neighbor on an insert or a remove.
// ----------------------------------------------------------------------------
module slir_cell (
    input  logic                                 i_clk,
    input  slir_pkg::t_cell_ctl                  i_ctl,
    input  logic                                 i_occupied,
    input  logic signed [slir_pkg::VALUE_W-1:0]  i_value,
    input  logic signed [slir_pkg::VALUE_W-1:0]  i_left_entry,
    input  logic                                 i_left_lt,
    input  logic signed [slir_pkg::VALUE_W-1:0]  i_right_entry,
    output logic signed [slir_pkg::VALUE_W-1:0]  o_entry,
    output logic                                 o_lt,
    output logic                                 o_eq
);
    import slir_pkg::*;

    logic signed [VALUE_W-1:0] r_entry;
    logic signed [VALUE_W-1:0] n_entry;

    assign o_entry = r_entry;
    assign o_lt    = i_occupied && (r_entry < i_value);
    assign o_eq    = i_occupied && (r_entry == i_value);

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins_en && !o_lt) begin
            n_entry = i_left_lt ? i_value : i_left_entry;
        end else if (i_ctl.rem_en && !o_lt) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the sorted list insert/remove block.
// ----------------------------------------------------------------------------
// A short directed table is run first. It covers a remove from the empty table,
// the signed extremes, duplicates, a fill to capacity, an insert that is
// dropped on a full table, and a remove that finds no match. Where the status
// can be read at a glance, the table row carries the expected status. Every
// other row is checked against a sorted copy of the table kept in the bench.
// After the table comes a random stream that swings between insert-heavy and
// remove-heavy stretches, so that the table fills and drains many times. Most
// removes name a value that is known to be stored.
// The sender and the receiver stall at random rates that change across the
// run. Each output beat is compared field by field with the oldest expected
// status.
// ----------------------------------------------------------------------------
module tb_top;

    import slir_pkg::*;

    localparam int DEPTH      = 16;
    localparam int N_DIRECTED = 25;
    localparam int N_RANDOM   = 750;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               not_found;
        logic               full_drop;
    } t_status;

    typedef struct packed {
        t_func                     func;
        logic signed [VALUE_W-1:0] value;
        logic                      typed;
        logic [COUNT_W-1:0]        count;
        logic                      not_found;
        logic                      full_drop;
    } t_row;

    localparam t_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{FUNC_REMOVE, 32'sd5,           1'b1, 5'd0,  1'b1, 1'b0},
        '{FUNC_INSERT, 32'sh7FFF_FFFF,   1'b1, 5'd1,  1'b0, 1'b0},
        '{FUNC_INSERT, 32'sh8000_0000,   1'b1, 5'd2,  1'b0, 1'b0},
        '{FUNC_INSERT, 32'sd0,           1'b1, 5'd3,  1'b0, 1'b0},
        '{FUNC_INSERT, 32'shFFFF_FFFF,   1'b1, 5'd4,  1'b0, 1'b0},
        '{FUNC_INSERT, 32'sd0,           1'b1, 5'd5,  1'b0, 1'b0},
        '{FUNC_REMOVE, 32'sd0,           1'b1, 5'd4,  1'b0, 1'b0},
        '{FUNC_REMOVE, 32'sd12345,       1'b1, 5'd4,  1'b1, 1'b0},
        '{FUNC_INSERT, 32'sh5555_5555,   1'b0, 5'd0,  1'b0, 1'b0},
        '{FUNC_INSERT, 32'shAAAA_AAAA,   1'b0, 5'd0,  1'b0, 1'b0},
        '{FUNC_INSERT, 32'sd1,           1'b0, 5'd0,  1'b0, 1'b0},
        '{FUNC_INSERT, 32'shFFFF_FFFE,   1'b0, 5'd0,  1'b0, 1'b0},
        '{FUNC_INSERT, 32'sd100,         1'b0, 5'd0,  1'b0, 1'b0},
        '{FUNC_INSERT, 32'shFFFF_FF9C,   1'b0, 5'd0,  1'b0, 1'b0},
        '{FUNC_INSERT, 32'sh7FFF_FFFF,   1'b0, 5'd0,  1'b0, 1'b0},
        '{FUNC_INSERT, 32'sh8000_0001,   1'b0, 5'd0,  1'b0, 1'b0},
        '{FUNC_INSERT, 32'sd42,          1'b0, 5'd0,  1'b0, 1'b0},
        '{FUNC_INSERT, 32'sd42,          1'b0, 5'd0,  1'b0, 1'b0},
        '{FUNC_INSERT, 32'sd7,           1'b0, 5'd0,  1'b0, 1'b0},
        '{FUNC_INSERT, 32'shFFFF_FFF9,   1'b0, 5'd0,  1'b0, 1'b0},
        '{FUNC_INSERT, 32'sd3,           1'b1, 5'd16, 1'b0, 1'b1},
        '{FUNC_REMOVE, 32'sh8000_0000,   1'b1, 5'd15, 1'b0, 1'b0},
        '{FUNC_REMOVE, 32'sh8000_0000,   1'b1, 5'd15, 1'b1, 1'b0},
        '{FUNC_INSERT, 32'sh8000_0000,   1'b1, 5'd16, 1'b0, 1'b0},
        '{FUNC_REMOVE, 32'sd42,          1'b0, 5'd0,  1'b0, 1'b0}
    };

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_ready;
    t_func                      i_func = FUNC_INSERT;
    logic signed [VALUE_W-1:0]  i_value = '0;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    logic [COUNT_W-1:0]         o_count;
    logic                       o_not_found;
    logic                       o_full_drop;

    logic signed [VALUE_W-1:0]  sorted_vals [DEPTH];
    int                         held_cnt = 0;
    t_status                    pending_status [$];
    int                         mismatch_cnt = 0;
    int                         rx_idle_pct = 87;
    int                         cycle_cnt = 0;

    sorted_list_insert_remove #(
        .DEPTH (DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_func      (i_func),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_count     (o_count),
        .o_not_found (o_not_found),
        .o_full_drop (o_full_drop)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Applies one operation to the bench's sorted copy and returns its status.
    function automatic t_status apply_to_sorted_copy(t_func func,
                                                     logic signed [VALUE_W-1:0] value);
        t_status st;
        int      pos;
        st = '0;
        pos = 0;
        if (func == FUNC_INSERT) begin
            if (held_cnt >= DEPTH) begin
                st.full_drop = 1'b1;
            end else begin
                while (pos < held_cnt && sorted_vals[pos] < value) pos++;
                for (int i = held_cnt; i > pos; i--) sorted_vals[i] = sorted_vals[i-1];
                sorted_vals[pos] = value;
                held_cnt++;
            end
        end else begin
            while (pos < held_cnt && sorted_vals[pos] != value) pos++;
            if (pos >= held_cnt) begin
                st.not_found = 1'b1;
            end else begin
                for (int i = pos; i + 1 < held_cnt; i++) sorted_vals[i] = sorted_vals[i+1];
                held_cnt--;
            end
        end
        st.count = held_cnt[COUNT_W-1:0];
        return st;
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return $signed($urandom_range(0, 15)) - 8;
        end else if (r < 60) begin
            case ($urandom_range(0, 3))
                0: return 32'sh7FFF_FFFF;
                1: return 32'sh8000_0000;
                2: return 32'sd0;
                default: return 32'shFFFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatch_cnt++;
    endtask

    // Drives one beat and returns at the edge where it is accepted.
    task automatic send_beat(int idx, t_func func, logic signed [VALUE_W-1:0] value);
        int phase;
        int tx_idle_pct;
        phase = idx * 3 / (N_DIRECTED + N_RANDOM);
        tx_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 87 : 0;
        rx_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 29 : 0;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func  <= func;
        i_value <= value;
        do @(posedge i_clk); while (!o_ready);
    endtask

    initial begin
        t_row                       row;
        t_status                    st;
        t_func                      func;
        logic signed [VALUE_W-1:0]  value;
        int                         insert_pct;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int k = 0; k < N_DIRECTED; k++) begin
            row = DIRECTED_ROWS[k];
            send_beat(k, row.func, row.value);
            st = apply_to_sorted_copy(row.func, row.value);
            if (row.typed) begin
                st = '{row.count, row.not_found, row.full_drop};
            end
            pending_status.push_back(st);
        end
        for (int k = 0; k < N_RANDOM; k++) begin
            insert_pct = ((k / 50) % 2 == 0) ? 30 : 80;
            func = ($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_REMOVE;
            if (func == FUNC_REMOVE && held_cnt != 0 && $urandom_range(0, 99) < 70) begin
                value = sorted_vals[$urandom_range(0, held_cnt - 1)];
            end else begin
                value = pick_value();
            end
            send_beat(N_DIRECTED + k, func, value);
            pending_status.push_back(apply_to_sorted_copy(func, value));
        end
        i_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        t_status want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_status.size() == 0) begin
                report_mismatch("unexpected beat, count", o_count, -1);
            end else begin
                want = pending_status.pop_front();
                if (o_count !== want.count) begin
                    report_mismatch("count", o_count, want.count);
                end
                if (o_not_found !== want.not_found) begin
                    report_mismatch("not_found", o_not_found, want.not_found);
                end
                if (o_full_drop !== want.full_drop) begin
                    report_mismatch("full_drop", o_full_drop, want.full_drop);
                end
            end
        end
        i_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule

// ===== sorted_list_insert_remove.f =====
hdl/slir_pkg.sv
hdl/slir_cell.sv
hdl/sorted_list_insert_remove.sv
dv/tb_top.sv
